// ===== sv/midpoint_ellipse_rasterizer_defines.svh =====
// Assertion macros for the ellipse rasterizer.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MER_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ellipse rasterizer check failed");
// next-cycle implication
`define MER_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ellipse rasterizer check failed");
`else
`define MER_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MER_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mer_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int CENTER_BITS     = 12;
  localparam int SLOPE_BITS      = 34;
  localparam int DEC_BITS        = 48;
  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 13;
  localparam int IN_QUEUE_DEPTH  = 2;
  localparam int OUT_QUEUE_DEPTH = 2;
  localparam int CFG_IDX_BITS    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_RADIUS_X,
    CFG_RADIUS_Y
  } cfg_reg_e;

  typedef struct packed {
    logic last_of_step;
    logic ellipse_done;
  } pix_flags_t;

endpackage

`default_nettype wire

// ===== sv/midpoint_ellipse_rasterizer.sv =====
// Channel   Handshake             Payload
// input     push / full           restart_i
// result    empty / pop           pixel_x_o, pixel_y_o, last_of_step_o, ellipse_done_o
// config    cfg_we_i (no wait)    cfg_idx_i, cfg_data_i
//
// A plain step runs pop, check, step update, decision update, region test, final test
// and four result words. A restart adds init, load and settle; region two's entry adds
// the squarings and products that seed its decision. The back sequencer and its single
// shared multiplier set these. No-result items leave the back after pop and check.
// Reset clears state to idle with no ellipse running; registers and squares read zero.
// Two-word queues on the input and result sides let either side stall on its own.
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_ellipse_rasterizer_defines.svh"

module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int CFG_W = (RADIUS_BITS > CENTER_BITS) ? RADIUS_BITS : CENTER_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    push,
  output logic                    full,
  input  logic                    restart_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_BITS-1:0]   pixel_x_o,
  output logic [COORD_BITS-1:0]   pixel_y_o,
  output logic                    last_of_step_o,
  output logic                    ellipse_done_o
);

  localparam int OUT_W = 2 * COORD_BITS + $bits(pix_flags_t);

  logic                     item_pop, item_restart, item_empty;
  logic [CENTER_BITS-1:0]   center_x, center_y;
  logic [RADIUS_BITS-1:0]   radius_y;
  logic [2*RADIUS_BITS-1:0] rx_sq, ry_sq;
  logic                     out_push, out_full;
  logic [COORD_BITS-1:0]    out_x, out_y;
  pix_flags_t               out_flags, rd_flags;
  logic [OUT_W-1:0]         out_word, rd_word;

  mer_front #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .restart_i      (restart_i),
    .full           (full),
    .item_pop_i     (item_pop),
    .item_restart_o (item_restart),
    .item_empty_o   (item_empty),
    .center_x_o     (center_x),
    .center_y_o     (center_y),
    .radius_y_o     (radius_y),
    .rx_sq_o        (rx_sq),
    .ry_sq_o        (ry_sq)
  );

  mer_back #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_empty_i   (item_empty),
    .item_restart_i (item_restart),
    .item_pop_o     (item_pop),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .radius_y_i     (radius_y),
    .rx_sq_i        (rx_sq),
    .ry_sq_i        (ry_sq),
    .out_full_i     (out_full),
    .out_push_o     (out_push),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_flags_o    (out_flags)
  );

  assign out_word = {out_x, out_y, out_flags};

  mer_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_word),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (rd_word),
    .empty_o (empty)
  );

  assign {pixel_x_o, pixel_y_o, rd_flags} = rd_word;
  assign last_of_step_o = rd_flags.last_of_step;
  assign ellipse_done_o = rd_flags.ellipse_done;

  `MER_ASSERT_IMP(a_out_no_overflow, clk_i, rst_ni, out_push, !out_full)
  `MER_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, item_pop, !item_empty)
  `MER_ASSERT_IMP(a_done_on_last, clk_i, rst_ni, !empty && ellipse_done_o, last_of_step_o)
  `MER_ASSERT_NXT(a_gap_after_step, clk_i, rst_ni, out_push && out_flags.last_of_step, !out_push)

endmodule

`default_nettype wire

// ===== sv/mer_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mer_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mer_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mer_front import mer_pkg::*; #(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  localparam int CFG_W = (RADIUS_BITS > CENTER_BITS) ? RADIUS_BITS : CENTER_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     push,
  input  logic                     restart_i,
  output logic                     full,
  input  logic                     item_pop_i,
  output logic                     item_restart_o,
  output logic                     item_empty_o,
  output logic [CENTER_BITS-1:0]   center_x_o,
  output logic [CENTER_BITS-1:0]   center_y_o,
  output logic [RADIUS_BITS-1:0]   radius_y_o,
  output logic [2*RADIUS_BITS-1:0] rx_sq_o,
  output logic [2*RADIUS_BITS-1:0] ry_sq_o
);

  localparam int SQ_W = 2 * RADIUS_BITS;

  logic [CENTER_BITS-1:0] center_x_q, center_y_q;
  logic [RADIUS_BITS-1:0] radius_x_q, radius_y_q;
  logic [SQ_W-1:0]        rx_sq_q, ry_sq_q;
  logic [SQ_W-1:0]        rx_ext, ry_ext;

  assign rx_ext = SQ_W'(radius_x_q);
  assign ry_ext = SQ_W'(radius_y_q);

  // squares follow the radius registers in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_x_q <= '0;
      radius_y_q <= '0;
      rx_sq_q    <= '0;
      ry_sq_q    <= '0;
    end else begin
      rx_sq_q <= rx_ext * rx_ext;
      ry_sq_q <= ry_ext * ry_ext;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_CENTER_X: center_x_q <= cfg_data_i[CENTER_BITS-1:0];
          CFG_CENTER_Y: center_y_q <= cfg_data_i[CENTER_BITS-1:0];
          CFG_RADIUS_X: radius_x_q <= cfg_data_i[RADIUS_BITS-1:0];
          CFG_RADIUS_Y: radius_y_q <= cfg_data_i[RADIUS_BITS-1:0];
          default:      center_x_q <= center_x_q;
        endcase
      end
    end
  end

  mer_fifo #(
    .WIDTH (1),
    .DEPTH (IN_QUEUE_DEPTH)
  ) u_item_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (restart_i),
    .full_o  (full),
    .pop_i   (item_pop_i),
    .data_o  (item_restart_o),
    .empty_o (item_empty_o)
  );

  assign center_x_o = center_x_q;
  assign center_y_o = center_y_q;
  assign radius_y_o = radius_y_q;
  assign rx_sq_o    = rx_sq_q;
  assign ry_sq_o    = ry_sq_q;

endmodule

`default_nettype wire

// ===== sv/mer_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mer_back import mer_pkg::*; #(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_empty_i,
  input  logic                     item_restart_i,
  output logic                     item_pop_o,
  input  logic [CENTER_BITS-1:0]   center_x_i,
  input  logic [CENTER_BITS-1:0]   center_y_i,
  input  logic [RADIUS_BITS-1:0]   radius_y_i,
  input  logic [2*RADIUS_BITS-1:0] rx_sq_i,
  input  logic [2*RADIUS_BITS-1:0] ry_sq_i,
  input  logic                     out_full_i,
  output logic                     out_push_o,
  output logic [COORD_BITS-1:0]    out_x_o,
  output logic [COORD_BITS-1:0]    out_y_o,
  output pix_flags_t               out_flags_o
);

  localparam int XS_BITS = RADIUS_BITS + 1;
  localparam int YS_BITS = RADIUS_BITS + 2;
  localparam int MUL_W   = 2 * RADIUS_BITS + 4;
  localparam int PROD_W  = 2 * MUL_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_LOAD, ST_SETTLE, ST_SQX, ST_SQY, ST_M3, ST_M4,
    ST_M5, ST_SETD, ST_CHECK, ST_UPD1, ST_UPD2, ST_FIN, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RG_IDLE, RG_ONE, RG_TWO, RG_DONE
  } region_e;

  state_e                 state_q;
  region_e                region_q;
  logic [XS_BITS-1:0]     step_x_q;
  logic [YS_BITS-1:0]     step_y_q;
  logic [SLOPE_BITS-1:0]  slope_x_q, slope_y_q;
  logic [DEC_BITS-1:0]    dec_q, prod_q, acc_q;
  logic [MUL_W-1:0]       sq_q;
  logic                   from_step_q, inc_x_q, dec_y_q, done_q;
  logic [1:0]             pix_idx_q;
  logic [COORD_BITS-1:0]  x_pos_q, x_neg_q, y_pos_q, y_neg_q;

  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [DEC_BITS-1:0]    prod_d;
  logic [XS_BITS:0]       tx;
  logic [YS_BITS:0]       ty, ty_neg;
  logic [YS_BITS-1:0]     ty_abs;
  logic [SLOPE_BITS-1:0]  rx_sq2, ry_sq2;
  logic [DEC_BITS-1:0]    rx_sq4, ry_sq4, dx4, dy4, dx_ext, dy_ext, prod4;
  logic                   dec_neg, dec_pos, slope_lt, y_below;
  logic [COORD_BITS-1:0]  cx, cy, px, py;

  assign tx      = {step_x_q, 1'b1};
  assign ty      = {step_y_q[YS_BITS-1], step_y_q} - (YS_BITS + 1)'(1);
  assign ty_neg  = -ty;
  assign ty_abs  = ty[YS_BITS] ? ty_neg[YS_BITS-1:0] : ty[YS_BITS-1:0];

  assign rx_sq2  = SLOPE_BITS'({rx_sq_i, 1'b0});
  assign ry_sq2  = SLOPE_BITS'({ry_sq_i, 1'b0});
  assign rx_sq4  = DEC_BITS'({rx_sq_i, 2'b00});
  assign ry_sq4  = DEC_BITS'({ry_sq_i, 2'b00});
  assign dx_ext  = {{(DEC_BITS - SLOPE_BITS){slope_x_q[SLOPE_BITS-1]}}, slope_x_q};
  assign dy_ext  = {{(DEC_BITS - SLOPE_BITS){slope_y_q[SLOPE_BITS-1]}}, slope_y_q};
  assign dx4     = {dx_ext[DEC_BITS-3:0], 2'b00};
  assign dy4     = {dy_ext[DEC_BITS-3:0], 2'b00};
  assign prod4   = {prod_q[DEC_BITS-3:0], 2'b00};

  assign dec_neg  = dec_q[DEC_BITS-1];
  assign dec_pos  = !dec_neg && (dec_q != '0);
  assign slope_lt = $signed(slope_x_q) < $signed(slope_y_q);
  assign y_below  = step_y_q[YS_BITS-1];

  assign cx = COORD_BITS'(signed'(center_x_i));
  assign cy = COORD_BITS'(signed'(center_y_i));
  assign px = COORD_BITS'(step_x_q);
  assign py = COORD_BITS'(signed'(step_y_q));

  // one shared multiplier, product registered every cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_INIT: begin
        mul_a = MUL_W'(rx_sq_i);
        mul_b = MUL_W'(radius_y_i);
      end
      ST_SQX: begin
        mul_a = MUL_W'(tx);
        mul_b = MUL_W'(tx);
      end
      ST_SQY: begin
        mul_a = MUL_W'(ty_abs);
        mul_b = MUL_W'(ty_abs);
      end
      ST_M3: begin
        mul_a = MUL_W'(ry_sq_i);
        mul_b = sq_q;
      end
      ST_M4: begin
        mul_a = MUL_W'(rx_sq_i);
        mul_b = sq_q;
      end
      ST_M5: begin
        mul_a = MUL_W'(rx_sq_i);
        mul_b = MUL_W'(ry_sq_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_d = DEC_BITS'(mul_p);

  assign item_pop_o = (state_q == ST_IDLE) && !item_empty_i;
  assign out_push_o = (state_q == ST_EMIT) && !out_full_i;
  assign out_x_o    = pix_idx_q[0] ? x_neg_q : x_pos_q;
  assign out_y_o    = pix_idx_q[1] ? y_neg_q : y_pos_q;
  assign out_flags_o.last_of_step = &pix_idx_q;
  assign out_flags_o.ellipse_done = (&pix_idx_q) && done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      region_q    <= RG_IDLE;
      step_x_q    <= '0;
      step_y_q    <= '0;
      slope_x_q   <= '0;
      slope_y_q   <= '0;
      dec_q       <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      sq_q        <= '0;
      from_step_q <= 1'b0;
      inc_x_q     <= 1'b0;
      dec_y_q     <= 1'b0;
      done_q      <= 1'b0;
      pix_idx_q   <= '0;
      x_pos_q     <= '0;
      x_neg_q     <= '0;
      y_pos_q     <= '0;
      y_neg_q     <= '0;
    end else begin
      prod_q <= prod_d;
      case (state_q)
        ST_IDLE: begin
          if (!item_empty_i) begin
            from_step_q <= 1'b0;
            state_q     <= item_restart_i ? ST_INIT : ST_CHECK;
          end
        end
        ST_INIT: state_q <= ST_LOAD;
        ST_LOAD: begin
          step_x_q  <= '0;
          step_y_q  <= YS_BITS'(radius_y_i);
          slope_x_q <= '0;
          slope_y_q <= {prod_q[SLOPE_BITS-2:0], 1'b0};
          dec_q     <= ry_sq4 + DEC_BITS'(rx_sq_i) - prod4;
          region_q  <= RG_ONE;
          state_q   <= ST_SETTLE;
        end
        ST_SETTLE: begin
          if (region_q == RG_ONE && !slope_lt) begin
            state_q <= ST_SQX;
          end else begin
            state_q <= from_step_q ? ST_FIN : ST_CHECK;
          end
        end
        ST_SQX: state_q <= ST_SQY;
        ST_SQY: begin
          sq_q    <= MUL_W'(prod_q);
          state_q <= ST_M3;
        end
        ST_M3: begin
          sq_q    <= MUL_W'(prod_q);
          state_q <= ST_M4;
        end
        ST_M4: begin
          acc_q   <= prod_q;
          state_q <= ST_M5;
        end
        ST_M5: begin
          acc_q   <= acc_q + prod4;
          state_q <= ST_SETD;
        end
        ST_SETD: begin
          // region-two decision: ry2*tx^2 + 4*rx2*ty^2 - 4*rx2*ry2
          dec_q    <= acc_q - prod4;
          region_q <= RG_TWO;
          state_q  <= from_step_q ? ST_FIN : ST_CHECK;
        end
        ST_CHECK: begin
          if (region_q != RG_ONE && region_q != RG_TWO) begin
            state_q <= ST_IDLE;
          end else if (region_q == RG_TWO && y_below) begin
            region_q <= RG_DONE;
            state_q  <= ST_IDLE;
          end else begin
            x_pos_q <= cx + px;
            x_neg_q <= cx - px;
            y_pos_q <= cy + py;
            y_neg_q <= cy - py;
            state_q <= ST_UPD1;
          end
        end
        ST_UPD1: begin
          if (region_q == RG_ONE) begin
            step_x_q  <= step_x_q + XS_BITS'(1);
            slope_x_q <= slope_x_q + ry_sq2;
            dec_q     <= dec_q + ry_sq4;
            inc_x_q   <= 1'b1;
            dec_y_q   <= !dec_neg;
            if (!dec_neg) begin
              step_y_q  <= step_y_q - YS_BITS'(1);
              slope_y_q <= slope_y_q - rx_sq2;
            end
          end else begin
            step_y_q  <= step_y_q - YS_BITS'(1);
            slope_y_q <= slope_y_q - rx_sq2;
            dec_q     <= dec_q + rx_sq4;
            inc_x_q   <= !dec_pos;
            dec_y_q   <= 1'b1;
            if (!dec_pos) begin
              step_x_q  <= step_x_q + XS_BITS'(1);
              slope_x_q <= slope_x_q + ry_sq2;
            end
          end
          state_q <= ST_UPD2;
        end
        ST_UPD2: begin
          // fold in the updated slope terms
          dec_q       <= dec_q + (inc_x_q ? dx4 : '0) - (dec_y_q ? dy4 : '0);
          from_step_q <= 1'b1;
          state_q     <= ST_SETTLE;
        end
        ST_FIN: begin
          if (region_q == RG_TWO && y_below) begin
            region_q <= RG_DONE;
            done_q   <= 1'b1;
          end else begin
            done_q   <= 1'b0;
          end
          pix_idx_q <= '0;
          state_q   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_full_i) begin
            pix_idx_q <= pix_idx_q + 2'd1;
            if (&pix_idx_q) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/midpoint_ellipse_rasterizer_tb.sv =====
`timescale 1ns / 1ps

class ellipse_tracker;
  localparam int CW = mer_pkg::COORD_BITS_DEF;
  localparam int RW = mer_pkg::RADIUS_BITS_DEF;
  localparam int SW = mer_pkg::SLOPE_BITS;
  localparam int DW = mer_pkg::DEC_BITS;
  localparam int NW = mer_pkg::CENTER_BITS;

  typedef enum logic [1:0] {ARC_IDLE, ARC_ONE, ARC_TWO, ARC_DONE} arc_e;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic          last;
    logic          done;
  } pixel_t;

  logic signed [NW-1:0] cx, cy;
  logic [RW-1:0]        rx, ry;
  logic [RW:0]          step_x;
  logic signed [RW+1:0] step_y;
  logic signed [SW-1:0] slope_x, slope_y;
  logic signed [DW-1:0] decision;
  arc_e                 arc;
  pixel_t               pixels_due[$];
  int                   errors, checked, finished;

  function new();
    cx = '0;
    cy = '0;
    rx = '0;
    ry = '0;
    step_x = '0;
    step_y = '0;
    slope_x = '0;
    slope_y = '0;
    decision = '0;
    arc = ARC_IDLE;
    errors = 0;
    checked = 0;
    finished = 0;
  endfunction

  function void flag(string what);
    errors++;
    if (errors <= 100) $display("MISMATCH at %0t: %s", $time, what);
  endfunction

  function void write_reg(mer_pkg::cfg_reg_e idx, logic [NW-1:0] data);
    case (idx)
      mer_pkg::CFG_CENTER_X: cx = data;
      mer_pkg::CFG_CENTER_Y: cy = data;
      mer_pkg::CFG_RADIUS_X: rx = data[RW-1:0];
      default:               ry = data[RW-1:0];
    endcase
  endfunction

  function bit running();
    return arc == ARC_ONE || arc == ARC_TWO;
  endfunction

  // Leave region one once the slopes cross; seed the region-two decision (x4).
  function void check_region_change();
    longint rx2, ry2, tx, ty, d;
    if (arc == ARC_ONE && !(slope_x < slope_y)) begin
      rx2 = longint'(rx) * longint'(rx);
      ry2 = longint'(ry) * longint'(ry);
      tx = 2 * longint'(step_x) + 1;
      ty = longint'(step_y) - 1;
      d = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
      decision = d[DW-1:0];
      arc = ARC_TWO;
    end
  endfunction

  function int take_step(bit restart);
    longint        rx2, ry2, d, t, px, py;
    logic [CW-1:0] xs[4], ys[4];
    bit            neg, pos, done;
    pixel_t        w;
    int            k;
    rx2 = longint'(rx) * longint'(rx);
    ry2 = longint'(ry) * longint'(ry);
    if (restart) begin
      step_x = '0;
      step_y = $signed({2'b00, ry});
      slope_x = '0;
      t = 2 * rx2 * longint'(ry);
      slope_y = t[SW-1:0];
      d = 4 * ry2 - 4 * rx2 * longint'(ry) + rx2;
      decision = d[DW-1:0];
      arc = ARC_ONE;
      check_region_change();
    end
    if (arc != ARC_ONE && arc != ARC_TWO) return 0;
    if (arc == ARC_TWO && step_y < 0) begin
      arc = ARC_DONE;
      return 0;
    end

    px = longint'(step_x);
    py = longint'(step_y);
    for (k = 0; k < 4; k++) begin
      t = k[0] ? longint'(cx) - px : longint'(cx) + px;
      xs[k] = t[CW-1:0];
      t = k[1] ? longint'(cy) - py : longint'(cy) + py;
      ys[k] = t[CW-1:0];
    end

    d = longint'(decision);
    if (arc == ARC_ONE) begin
      neg = decision < 0;
      step_x = step_x + 1'b1;
      t = longint'(slope_x) + 2 * ry2;
      slope_x = t[SW-1:0];
      if (neg) begin
        d = d + 4 * longint'(slope_x) + 4 * ry2;
      end else begin
        step_y = step_y - 1'b1;
        t = longint'(slope_y) - 2 * rx2;
        slope_y = t[SW-1:0];
        d = d + 4 * longint'(slope_x) - 4 * longint'(slope_y) + 4 * ry2;
      end
      decision = d[DW-1:0];
      check_region_change();
    end else begin
      pos = decision > 0;
      step_y = step_y - 1'b1;
      t = longint'(slope_y) - 2 * rx2;
      slope_y = t[SW-1:0];
      if (pos) begin
        d = d + 4 * rx2 - 4 * longint'(slope_y);
      end else begin
        step_x = step_x + 1'b1;
        t = longint'(slope_x) + 2 * ry2;
        slope_x = t[SW-1:0];
        d = d + 4 * longint'(slope_x) - 4 * longint'(slope_y) + 4 * rx2;
      end
      decision = d[DW-1:0];
    end

    done = 1'b0;
    if (arc == ARC_TWO && step_y < 0) begin
      arc = ARC_DONE;
      done = 1'b1;
      finished++;
    end
    for (k = 0; k < 4; k++) begin
      w.px = xs[k];
      w.py = ys[k];
      w.last = (k == 3);
      w.done = (k == 3) && done;
      pixels_due = {pixels_due, w};
    end
    return 4;
  endfunction

  function void check_pixel(logic [CW-1:0] px, logic [CW-1:0] py, logic last, logic done);
    pixel_t want;
    if (pixels_due.size() == 0) begin
      flag($sformatf("unexpected word x=%0d y=%0d", $signed(px), $signed(py)));
      return;
    end
    want = pixels_due.pop_front();
    checked++;
    if (px !== want.px)
      flag($sformatf("pixel_x got %0d want %0d", $signed(px), $signed(want.px)));
    if (py !== want.py)
      flag($sformatf("pixel_y got %0d want %0d", $signed(py), $signed(want.py)));
    if (last !== want.last)
      flag($sformatf("last_of_step got %b want %b", last, want.last));
    if (done !== want.done)
      flag($sformatf("ellipse_done got %b want %b", done, want.done));
  endfunction
endclass

module midpoint_ellipse_rasterizer_tb;
  import mer_pkg::*;

  localparam int CFG_W = (RADIUS_BITS_DEF > CENTER_BITS) ? RADIUS_BITS_DEF : CENTER_BITS;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_STEPS = 100;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  cfg_reg_e                  cfg_idx_i = CFG_CENTER_X;
  logic [CFG_W-1:0]          cfg_data_i = '0;
  logic                      push = 1'b0;
  logic                      full;
  logic                      restart_i = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [COORD_BITS_DEF-1:0] pixel_x_o, pixel_y_o;
  logic                      last_of_step_o, ellipse_done_o;

  ellipse_tracker tracker;
  int             steps_sent = 0;
  int             steps_live = 0;
  int             quiet_cycles = 0;

  midpoint_ellipse_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .restart_i     (restart_i),
    .empty         (empty),
    .pop           (pop),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .last_of_step_o(last_of_step_o),
    .ellipse_done_o(ellipse_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Upper data bits are don't-care for the radius registers; keep them random.
  function automatic logic [CFG_W-1:0] pick_radius();
    int r;
    logic [RADIUS_BITS_DEF-1:0] rad;
    r = $urandom_range(0, 99);
    if (r < 78) rad = RADIUS_BITS_DEF'($urandom_range(0, 12));
    else if (r < 92) rad = RADIUS_BITS_DEF'($urandom_range(13, 60));
    else if (r < 96) rad = {RADIUS_BITS_DEF{1'b1}};
    else rad = RADIUS_BITS_DEF'($urandom_range(61, 1023));
    return {2'($urandom_range(0, 3)), rad};
  endfunction

  function automatic logic [CFG_W-1:0] pick_center();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 12'h800;
    if (r == 1) return 12'h7FF;
    return CFG_W'($urandom_range(0, 4095));
  endfunction

  // Caller stands at a falling edge; returns at a falling edge.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_regs(logic [3:0] which, logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
                           logic [CFG_W-1:0] rx, logic [CFG_W-1:0] ry);
    if (which[0]) write_reg(CFG_CENTER_X, cx);
    if (which[1]) write_reg(CFG_CENTER_Y, cy);
    if (which[2]) write_reg(CFG_RADIUS_X, rx);
    if (which[3]) write_reg(CFG_RADIUS_Y, ry);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_step(bit restart, bit burst);
    int gap;
    int made;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (full);
    made = tracker.take_step(restart);
    steps_sent++;
    if (made != 0) steps_live++;
    @(negedge clk_i);
  endtask

  // Drop push, wait for every due word, then cover steps that plot nothing.
  task automatic drain();
    push <= 1'b0;
    while (tracker.pixels_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int  gap;
    bit  pop_burst;
    pop_burst = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) pop_burst = ~pop_burst;
      gap = pop_burst ? 0 : pick_gap();
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      tracker.check_pixel(pixel_x_o, pixel_y_o, last_of_step_o, ellipse_done_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d words still due",
               quiet_cycles, tracker.pixels_due.size());
      $display("midpoint_ellipse_rasterizer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int        live_before, cap, n;
    bit        burst, fresh, first;
    logic [3:0] which;
    tracker = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no ellipse yet: step is dropped
    send_step(1'b0, 1'b1);
    drain();
    // zero radii, centre at the corners: one step plots and finishes
    load_regs(4'hF, 12'h800, 12'h7FF, 12'hC00, 12'hC00);
    send_step(1'b1, 1'b0);
    send_step(1'b0, 1'b0);
    drain();
    load_regs(4'hF, 12'h7FF, 12'h800, 12'd5, 12'd3);
    send_step(1'b1, 1'b0);
    while (tracker.running()) send_step(1'b0, 1'b0);
    drain();
    // largest radii; abandon the ellipse with a second restart
    load_regs(4'hF, 12'd0, 12'd0, 12'h3FF, 12'h3FF);
    send_step(1'b1, 1'b1);
    repeat (3) send_step(1'b0, 1'b1);
    send_step(1'b1, 1'b0);
    repeat (2) send_step(1'b0, 1'b0);
    drain();
    load_regs(4'b1100, 12'd0, 12'd0, 12'h3FF, 12'h000);
    send_step(1'b1, 1'b0);
    drain();
    // change centre and ry while an ellipse is in progress
    load_regs(4'hF, 12'd40, 12'hFE2, 12'd2, 12'd6);
    send_step(1'b1, 1'b0);
    repeat (2) send_step(1'b0, 1'b0);
    drain();
    load_regs(4'b1001, 12'd100, 12'd0, 12'd0, 12'd1);
    n = 0;
    while (tracker.running() && n < 10) begin
      send_step(1'b0, 1'b0);
      n++;
    end

    live_before = steps_live;
    first = 1'b1;
    while (steps_live - live_before < RANDOM_STEPS) begin
      drain();
      burst = ($urandom_range(0, 4) == 0);
      which = first ? 4'hF : 4'($urandom_range(0, 15));
      first = 1'b0;
      load_regs(which, pick_center(), pick_center(), pick_radius(), pick_radius());
      fresh = ($urandom_range(0, 9) != 0);
      cap = (tracker.rx > 60 || tracker.ry > 60) ? 16 : 48;
      send_step(fresh, burst);
      n = 0;
      while (tracker.running() && n < cap) begin
        send_step($urandom_range(0, 29) == 0, burst);
        n++;
      end
      if ($urandom_range(0, 2) == 0) send_step(1'b0, burst);
    end
    drain();

    $display("ran %0d step requests (%0d plotting), %0d pixel words checked",
             steps_sent, steps_live, tracker.checked);
    $display("%0d ellipses run to the end, %0d mismatches", tracker.finished, tracker.errors);
    if (tracker.errors == 0) begin
      $display("midpoint_ellipse_rasterizer_tb: done, clean");
    end else begin
      $display("midpoint_ellipse_rasterizer_tb: done, errors");
    end
    $finish;
  end
endmodule
